/* src/pfn_pkg.sv */
// ----------------------------------------------------------------------------
// pfn_pkg
// Shared types and constants of the fractal 2D gradient noise unit.
// ----------------------------------------------------------------------------
package pfn_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int FIX_ONE         = 1 << FRAC_BITS;
	localparam int DEF_MAX_OCTAVES = 8;
	localparam int PERM_W          = 8;
	localparam int TABLE_DEPTH     = 256;
	localparam int COORD_W         = 32;
	localparam int OCT_IN_W        = 4;
	localparam int OCT_W           = 5;
	localparam int NOISE_W         = 16;
	localparam int QUO_W           = 17;
	localparam int CNT_W           = 5;

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// One queued request between front and back
	typedef struct packed {
		logic                      cmd;
		logic [PERM_W-1:0]         idx;
		logic [PERM_W-1:0]         value;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] z;
		logic [OCT_W-1:0]          oct;
	} q_item_t;

	// Handshake from the queue head toward the back end
	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_head_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POINT,
		ST_RA,
		ST_RB,
		ST_HAA,
		ST_HAB,
		ST_HBA,
		ST_HBB,
		ST_LERP0,
		ST_LERP1,
		ST_LERP2,
		ST_DIV_INIT,
		ST_DIV,
		ST_OUT
	} back_state_t;

endpackage

/* src/pfn_ram.sv */
// ----------------------------------------------------------------------------
// pfn_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pfn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/pfn_front.sv */
// ----------------------------------------------------------------------------
// pfn_front
// Accepts requests, clamps the octave count and queues them (two entries).
// ----------------------------------------------------------------------------
module pfn_front import pfn_pkg::*; #(
	parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      command,
	input  logic [PERM_W-1:0]         table_index,
	input  logic [PERM_W-1:0]         table_value,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_z,
	input  logic [OCT_IN_W-1:0]       octave_count,
	output logic                      busy,
	output q_head_t                   head,
	input  logic                      pop
);

	q_item_t          entries_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic [OCT_W-1:0] oct_clamped;
	q_item_t          new_item;

	assign busy = (count_q == 2'd2);
	assign push = start && !busy;

	// Clamp octave count into 1..MAX_OCTAVES
	always_comb begin
		oct_clamped = OCT_W'(octave_count);
		priority if (octave_count == '0) begin
			oct_clamped = OCT_W'(1);
		end else if (OCT_W'(octave_count) > OCT_W'(MAX_OCTAVES)) begin
			oct_clamped = OCT_W'(MAX_OCTAVES);
		end
	end

	always_comb begin
		new_item.cmd   = command;
		new_item.idx   = table_index;
		new_item.value = table_value;
		new_item.x     = coord_x;
		new_item.z     = coord_z;
		new_item.oct   = oct_clamped;
	end

	// Queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= new_item;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.item  = entries_q[rd_ptr_q];

`ifndef ASSERT_OFF
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue fill level out of range");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !pop) |=> busy) else $error("full queue lost an entry");
`endif

endmodule

/* src/pfn_back.sv */
// ----------------------------------------------------------------------------
// pfn_back
// Executes queued requests: table loads, and octave-by-octave noise
// evaluation through one shared multiplier, then a bit-serial normalizing
// divide and saturation.
// ----------------------------------------------------------------------------
module pfn_back import pfn_pkg::*; #(
	parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  q_head_t                   head,
	output logic                      pop,
	output logic                      done,
	output logic signed [NOISE_W-1:0] noise_value
);

	localparam int SUM_W = 19 + MAX_OCTAVES;
	localparam int DIV_W = SUM_W + 1;
	localparam int G_W   = 20;
	localparam int M_W   = 24;

	back_state_t state_q, state_d;

	// Sample and octave registers
	logic signed [COORD_W-1:0] x_q, z_q;
	logic [OCT_W-1:0]          oct_n_q, oct_i_q;
	logic [PERM_W-1:0]         xi_q, zi_q, ra_q, rb_q;
	logic [PERM_W-1:0]         haa_q, hab_q, hba_q, hbb_q;
	logic [FRAC_BITS-1:0]      xf_q, zf_q, t2_q, t3_q;
	logic [FRAC_BITS:0]        fu_q, fv_q;
	logic signed [G_W-1:0]     n0_q, n1_q;
	logic signed [SUM_W-1:0]   sum_q;
	// Divider registers
	logic                      neg_q;
	logic [DIV_W-1:0]          rem_q, dvs_q;
	logic [QUO_W-1:0]          quo_q;
	logic [CNT_W-1:0]          cnt_q;

	// Memory port
	logic              ram_we;
	logic [PERM_W-1:0] ram_raddr, ram_rdata;

	// Shared multiplier
	logic signed [M_W-1:0]   a_op, b_op;
	logic signed [2*M_W-1:0] prod;

	logic [COORD_W-1:0]       xs_sh, zs_sh;
	logic [FRAC_BITS-1:0]     t_cur;
	logic signed [M_W-1:0]    q_fade;
	logic signed [17:0]       xs0, xs1, zs0, zs1;
	logic signed [G_W-1:0]    g_aa, g_ab, g_ba, g_bb;
	logic signed [M_W-1:0]    lp, lerp_sum;
	logic [MAX_OCTAVES:0]     pow_n;
	logic [MAX_OCTAVES-1:0]   d_w;
	logic [SUM_W-1:0]         abs_s;
	logic [QUO_W-1:0]         quo_next;

	function automatic logic signed [G_W-1:0] grad(input logic [3:0] g,
		input logic signed [17:0] x, input logic signed [17:0] y);
		logic signed [G_W-1:0] u;
		logic signed [G_W-1:0] v;
		u = (g < 4'd8) ? G_W'(x) : G_W'(y);
		if (g < 4'd4) begin
			v = G_W'(y);
		end else if (g == 4'd12 || g == 4'd14) begin
			v = G_W'(x);
		end else begin
			v = '0;
		end
		return (g[0] ? -u : u) + (g[1] ? -v : v);
	endfunction

	pfn_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_DEPTH)) u_perm (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head.item.idx),
		.wdata (head.item.value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Scaled point: cell bits and fraction of coord << octave
	assign xs_sh = x_q << oct_i_q;
	assign zs_sh = z_q << oct_i_q;

	// Fade polynomial term, never negative
	assign t_cur  = (state_q == ST_HAA) ? xf_q : zf_q;
	assign q_fade = $signed({8'b0, t2_q}) * 24'sd6 - $signed({8'b0, t_cur}) * 24'sd15
		+ M_W'(10 * FIX_ONE);

	// Corner offsets and gradients
	assign xs0  = $signed({2'b00, xf_q});
	assign zs0  = $signed({2'b00, zf_q});
	assign xs1  = xs0 - 18'(FIX_ONE);
	assign zs1  = zs0 - 18'(FIX_ONE);
	assign g_aa = grad(haa_q[3:0], xs0, zs0);
	assign g_ba = grad(hba_q[3:0], xs1, zs0);
	assign g_ab = grad(hab_q[3:0], xs0, zs1);
	assign g_bb = grad(hbb_q[3:0], xs1, zs1);

	// Multiplier operand select
	always_comb begin
		a_op = '0;
		b_op = '0;
		unique case (state_q)
			ST_RA: begin
				a_op = $signed({8'b0, xf_q});
				b_op = $signed({8'b0, xf_q});
			end
			ST_RB: begin
				a_op = $signed({8'b0, t2_q});
				b_op = $signed({8'b0, xf_q});
			end
			ST_HAA, ST_HBB: begin
				a_op = $signed({8'b0, t3_q});
				b_op = q_fade;
			end
			ST_HAB: begin
				a_op = $signed({8'b0, zf_q});
				b_op = $signed({8'b0, zf_q});
			end
			ST_HBA: begin
				a_op = $signed({8'b0, t2_q});
				b_op = $signed({8'b0, zf_q});
			end
			ST_LERP0: begin
				a_op = M_W'(g_ba) - M_W'(g_aa);
				b_op = $signed({7'b0, fu_q});
			end
			ST_LERP1: begin
				a_op = M_W'(g_bb) - M_W'(g_ab);
				b_op = $signed({7'b0, fu_q});
			end
			ST_LERP2: begin
				a_op = M_W'(n1_q) - M_W'(n0_q);
				b_op = $signed({7'b0, fv_q});
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign prod = a_op * b_op;
	// Floor shift of the interpolation product
	assign lp   = $signed(prod[FRAC_BITS+M_W-1:FRAC_BITS]);

	always_comb begin
		unique case (state_q)
			ST_LERP0: lerp_sum = M_W'(g_aa) + lp;
			ST_LERP1: lerp_sum = M_W'(g_ab) + lp;
			default:  lerp_sum = M_W'(n0_q) + lp;
		endcase
	end

	// Weight sum and divider setup
	assign pow_n    = (MAX_OCTAVES+1)'(1) << oct_n_q;
	assign d_w      = MAX_OCTAVES'(pow_n - 1'b1);
	assign abs_s    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign quo_next = {quo_q[QUO_W-2:0], (rem_q >= dvs_q)};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid && head.item.cmd == CMD_EVAL) begin
					state_d = ST_POINT;
				end
			end
			ST_POINT:    state_d = ST_RA;
			ST_RA:       state_d = ST_RB;
			ST_RB:       state_d = ST_HAA;
			ST_HAA:      state_d = ST_HAB;
			ST_HAB:      state_d = ST_HBA;
			ST_HBA:      state_d = ST_HBB;
			ST_HBB:      state_d = ST_LERP0;
			ST_LERP0:    state_d = ST_LERP1;
			ST_LERP1:    state_d = ST_LERP2;
			ST_LERP2: begin
				state_d = (oct_i_q == oct_n_q - OCT_W'(1)) ? ST_DIV_INIT : ST_POINT;
			end
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT:      state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Outputs: queue pop, table write and read address
	always_comb begin
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				pop    = head.valid;
				ram_we = head.valid && head.item.cmd == CMD_LOAD;
			end
			ST_POINT: ram_raddr = xs_sh[FRAC_BITS+PERM_W-1:FRAC_BITS];
			ST_RA:    ram_raddr = xi_q + PERM_W'(1);
			ST_RB:    ram_raddr = ra_q + zi_q;
			ST_HAA:   ram_raddr = ra_q + zi_q + PERM_W'(1);
			ST_HAB:   ram_raddr = rb_q + zi_q;
			ST_HBA:   ram_raddr = rb_q + zi_q + PERM_W'(1);
			default:  ram_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q     <= head.item.x;
				z_q     <= head.item.z;
				oct_n_q <= head.item.oct;
				oct_i_q <= '0;
				sum_q   <= '0;
			end
			ST_POINT: begin
				xi_q <= xs_sh[FRAC_BITS+PERM_W-1:FRAC_BITS];
				zi_q <= zs_sh[FRAC_BITS+PERM_W-1:FRAC_BITS];
				xf_q <= xs_sh[FRAC_BITS-1:0];
				zf_q <= zs_sh[FRAC_BITS-1:0];
			end
			ST_RA: begin
				ra_q <= ram_rdata;
				t2_q <= prod[2*FRAC_BITS-1:FRAC_BITS];
			end
			ST_RB: begin
				rb_q <= ram_rdata;
				t3_q <= prod[2*FRAC_BITS-1:FRAC_BITS];
			end
			ST_HAA: begin
				haa_q <= ram_rdata;
				fu_q  <= prod[2*FRAC_BITS:FRAC_BITS];
			end
			ST_HAB: begin
				hab_q <= ram_rdata;
				t2_q  <= prod[2*FRAC_BITS-1:FRAC_BITS];
			end
			ST_HBA: begin
				hba_q <= ram_rdata;
				t3_q  <= prod[2*FRAC_BITS-1:FRAC_BITS];
			end
			ST_HBB: begin
				hbb_q <= ram_rdata;
				fv_q  <= prod[2*FRAC_BITS:FRAC_BITS];
			end
			ST_LERP0: n0_q <= lerp_sum[G_W-1:0];
			ST_LERP1: n1_q <= lerp_sum[G_W-1:0];
			ST_LERP2: begin
				// Horner: earlier octaves carry the larger weights
				sum_q   <= (sum_q <<< 1) + SUM_W'($signed(lerp_sum[G_W-1:0]));
				oct_i_q <= oct_i_q + OCT_W'(1);
			end
			ST_DIV_INIT: begin
				neg_q <= sum_q[SUM_W-1];
				rem_q <= DIV_W'(abs_s) + DIV_W'({d_w, 1'b0});
				dvs_q <= DIV_W'({d_w, 2'b00}) << (QUO_W - 1);
				quo_q <= '0;
				cnt_q <= CNT_W'(QUO_W - 1);
			end
			ST_DIV: begin
				// Restoring divide, one quotient bit per cycle
				if (rem_q >= dvs_q) begin
					rem_q <= rem_q - dvs_q;
				end
				quo_q <= quo_next;
				dvs_q <= dvs_q >> 1;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Saturate to Q1.14
	always_comb begin
		if (!neg_q) begin
			noise_value = (quo_q > QUO_W'(32767)) ? 16'sh7FFF : $signed(quo_q[15:0]);
		end else begin
			noise_value = (quo_q > QUO_W'(32768)) ? 16'sh8000 : -$signed(quo_q[15:0]);
		end
	end

	assign done = (state_q == ST_OUT);

`ifndef ASSERT_OFF
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> dvs_q != '0) else $error("zero divisor in normalize");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_IDLE) else $error("queue pop outside idle");
`endif

endmodule

/* src/perlin_fbm_noise_2d_unit.sv */
// ----------------------------------------------------------------------------
// perlin_fbm_noise_2d_unit
// Fractal 2D gradient noise: table load and evaluate requests.
// ----------------------------------------------------------------------------
// A load writes the table in the back end's idle state as it leaves the queue; an evaluate
// steps through its octaves on the shared multiplier and table read port, then divider
// setup, a bit-serial divide, output and a return to idle. The back end finishes one
// request before it takes the next from the queue.
// Two-entry request queue; busy is high while it is full. done cannot stall.
// Reset clears control state; the permutation table is undefined until loaded.
module perlin_fbm_noise_2d_unit import pfn_pkg::*; #(
	parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      command,
	input  logic [PERM_W-1:0]         table_index,
	input  logic [PERM_W-1:0]         table_value,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_z,
	input  logic [OCT_IN_W-1:0]       octave_count,
	output logic                      done,
	output logic signed [NOISE_W-1:0] noise_value
);

	q_head_t head;
	logic    pop;

	// Accept and queue requests
	pfn_front #(.MAX_OCTAVES(MAX_OCTAVES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.command      (command),
		.table_index  (table_index),
		.table_value  (table_value),
		.coord_x      (coord_x),
		.coord_z      (coord_z),
		.octave_count (octave_count),
		.busy         (busy),
		.head         (head),
		.pop          (pop)
	);

	// Execute requests
	pfn_back #(.MAX_OCTAVES(MAX_OCTAVES)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.done        (done),
		.noise_value (noise_value)
	);

endmodule
